[rtl/scalar_kalman_warmup_filter_core_macros.svh]
// Assertion macros used by the filter core RTL.
`ifndef SCALAR_KALMAN_WARMUP_FILTER_CORE_MACROS_SVH
`define SCALAR_KALMAN_WARMUP_FILTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKWF_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("skwf: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SKWF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("skwf: next-cycle check failed");

`endif

[rtl/skwf_pkg.sv]
`default_nettype none
package skwf_pkg;
  localparam int CHANNELS = 3;
  localparam int WARMUP   = 128;
  localparam int CH_W     = 2;
  localparam int SMP_W    = 32;
  localparam int FRAC_W   = 24;
  localparam int CNT_W    = 8;
  localparam int IDX_W    = 1;

  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
  localparam logic [IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

  localparam logic [FRAC_W-1:0] Q_RESET = 24'd335544;
  localparam logic [FRAC_W-1:0] R_RESET = 24'd1677722;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_FIN  = 6'b010000,
    S_PUT  = 6'b100000
  } state_t;
endpackage
`default_nettype wire

[rtl/scalar_kalman_warmup_filter_core.sv]
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_channel, in_sample
// out     | output    | out_valid/out_stall| out_estimate
// cfg     | input     | cfg_we             | cfg_index, cfg_wdata
// A warmup beat runs the bit-serial gain divider, then the bit-serial multipliers that
// form the new variance and the correction. After warmup only the multipliers run.
// A beat with a channel out of range goes from S_IDLE straight to S_PUT and returns zero
// through the output register once that register is free to take it.
// Reset is synchronous and clears all channel state; a finished result waits in the
// output register while the next beat is already taken.
`default_nettype none
module scalar_kalman_warmup_filter_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [skwf_pkg::CH_W-1:0]       in_channel,
  input  wire logic signed [skwf_pkg::SMP_W-1:0] in_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [skwf_pkg::SMP_W-1:0]    out_estimate,
  input  wire logic                            cfg_we,
  input  wire logic [skwf_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [skwf_pkg::FRAC_W-1:0]     cfg_wdata
);
  import skwf_pkg::*;
  `include "scalar_kalman_warmup_filter_core_macros.svh"

  state_t                   state_r, state_nxt;
  logic [FRAC_W-1:0]        q_r, r_r;
  logic signed [SMP_W-1:0]  est_r  [CHANNELS];
  logic [FRAC_W-1:0]        pvar_r [CHANNELS];
  logic [FRAC_W-1:0]        gain_r [CHANNELS];
  logic [CNT_W-1:0]         wcnt_r [CHANNELS];

  logic [CH_W-1:0]          ch_r;
  logic signed [SMP_W-1:0]  smp_r, x_r, res_r;
  logic signed [SMP_W:0]    diff_r;
  logic                     warm_r;
  logic [FRAC_W+2:0]        rem_r;
  logic [FRAC_W+1:0]        den_r;
  logic [FRAC_W:0]          quo_r;
  logic [4:0]               bit_r;
  logic [FRAC_W-1:0]        k_r;
  logic [FRAC_W:0]          pacc_r;
  logic signed [SMP_W+2:0]  cacc_r;
  logic                     out_valid_r;
  logic signed [SMP_W-1:0]  out_est_r;

  logic [FRAC_W:0]          ptemp;
  logic [FRAC_W+1:0]        den;
  logic                     ge;
  logic [FRAC_W+2:0]        rem_sub;
  logic [FRAC_W:0]          quo_nxt;
  logic [FRAC_W:0]          pacc_sum;
  logic signed [SMP_W+2:0]  cacc_sum;
  logic signed [SMP_W+2:0]  est_sum;
  logic signed [SMP_W-1:0]  est_clamp;
  logic                     put_ok;

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign put_ok       = !out_valid_r || !out_stall;

  always_comb begin
    ptemp    = {1'b0, pvar_r[ch_r]} + {1'b0, q_r};
    den      = {1'b0, ptemp} + {2'b00, r_r};
    ge       = (rem_r >= {1'b0, den_r});
    rem_sub  = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    quo_nxt  = {quo_r[FRAC_W-1:0], ge};
    pacc_sum = pacc_r + (k_r[0] ? {1'b0, r_r} : '0);
    cacc_sum = cacc_r + (k_r[0] ? {{2{diff_r[SMP_W]}}, diff_r} : '0);
    est_sum  = {{3{x_r[SMP_W-1]}}, x_r} + cacc_r;
    if (est_sum > $signed({4'b0000, {(SMP_W-1){1'b1}}})) begin
      est_clamp = {1'b0, {(SMP_W-1){1'b1}}};
    end else if (est_sum < $signed({4'b1111, {(SMP_W-1){1'b0}}})) begin
      est_clamp = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      est_clamp = est_sum[SMP_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = ({{(32-CH_W){1'b0}}, in_channel} < CHANNELS) ? S_LOAD : S_PUT;
        end
      end
      S_LOAD: begin
        if (wcnt_r[ch_r] < CNT_W'(WARMUP) && den != '0) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        if (bit_r == 5'(FRAC_W)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (bit_r == 5'(FRAC_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: state_nxt = S_PUT;
      S_PUT: begin
        if (put_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_r         <= Q_RESET;
      r_r         <= R_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        est_r[i]  <= '0;
        pvar_r[i] <= '0;
        gain_r[i] <= '0;
        wcnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE:     q_r <= cfg_wdata;
          REG_MEASUREMENT_NOISE: r_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_PUT && put_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_FIN) begin
        est_r[ch_r] <= est_clamp;
        if (warm_r) begin
          pvar_r[ch_r] <= pacc_r[FRAC_W-1:0];
          gain_r[ch_r] <= k_r;
          wcnt_r[ch_r] <= wcnt_r[ch_r] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ch_r  <= in_channel;
        smp_r <= in_sample;
        res_r <= '0;
      end
      S_LOAD: begin
        x_r    <= est_r[ch_r];
        diff_r <= {smp_r[SMP_W-1], smp_r} - {est_r[ch_r][SMP_W-1], est_r[ch_r]};
        warm_r <= (wcnt_r[ch_r] < CNT_W'(WARMUP));
        rem_r  <= {2'b00, ptemp};
        den_r  <= den;
        quo_r  <= '0;
        bit_r  <= '0;
        pacc_r <= '0;
        cacc_r <= '0;
        k_r    <= (wcnt_r[ch_r] < CNT_W'(WARMUP)) ? '0 : gain_r[ch_r];
      end
      S_DIV: begin
        rem_r <= {rem_sub[FRAC_W+1:0], 1'b0};
        quo_r <= quo_nxt;
        if (bit_r == 5'(FRAC_W)) begin
          bit_r <= '0;
          k_r   <= quo_nxt[FRAC_W] ? '1 : quo_nxt[FRAC_W-1:0];
        end else begin
          bit_r <= bit_r + 1'b1;
        end
      end
      S_MUL: begin
        pacc_r <= {1'b0, pacc_sum[FRAC_W:1]};
        cacc_r <= cacc_sum >>> 1;
        k_r    <= {k_r[0], k_r[FRAC_W-1:1]};
        bit_r  <= bit_r + 1'b1;
      end
      S_FIN: res_r <= est_clamp;
      S_PUT: begin
        if (put_ok) begin
          out_est_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  `SKWF_ASSERT_NOW(a_mul_count, (state_r == S_MUL), (bit_r < 5'(FRAC_W)))
  `SKWF_ASSERT_NOW(a_div_rem, (state_r == S_DIV), (rem_r < {den_r, 1'b0}))
  `SKWF_ASSERT_NOW(a_warm_limit, (state_r == S_FIN && warm_r), (wcnt_r[ch_r] < CNT_W'(WARMUP)))
  `SKWF_ASSERT_NEXT(a_put_loads, (state_r == S_PUT && put_ok), (out_valid_r && state_r == S_IDLE))

endmodule
`default_nettype wire
